### rtl/snaw_pkg.sv
// Shared types and codes for the strided N-dimensional address walker.
// No dependencies; imported by snaw_ctrl, snaw_dpath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package snaw_pkg;

  // Input word kinds; code 3 carries no meaning and is dropped.
  typedef enum logic [1:0] {
    KIND_DESC    = 2'd0,
    KIND_RESTART = 2'd1,
    KIND_STEP    = 2'd2
  } kind_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ACTIVE_DIMS = 2'd0;
  localparam logic [1:0] CFG_BASE_DEST   = 2'd1;
  localparam logic [1:0] CFG_BASE_FIRST  = 2'd2;
  localparam logic [1:0] CFG_BASE_SECOND = 2'd3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic desc_wr;   // write descriptor tables from the input word
    logic restart;   // reload counters and offsets
    logic start;     // capture current offsets, point at innermost dim
    logic walk;      // advance the pointed dimension by one
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic wrap;       // pointed counter runs out on this advance
    logic ptr_zero;   // pointer sits at the outermost dimension
    logic dims_zero;  // no active dimensions
  } status_t;

endpackage

`default_nettype wire

### rtl/strided_nd_address_walker.sv
// Top level of the strided N-dimensional address walker: configuration
// registers, output register, snaw_ctrl and snaw_dpath. Uses snaw_pkg.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+-------------------------------
//   in       | input     | in_valid_i/in_stall_o  | kind, dim_index, length, strides
//   out      | output    | out_valid_o/out_stall_i| three offsets, last
//   cfg      | input     | cfg_we_i               | cfg_index_i, cfg_wdata_i
//
// Descriptor write and restart are accepted from idle. A step walks the carry over
// k dimensions (1 up to the active count, 0 with no active dims), then emits: the
// walk advances one dimension per cycle through the shared offset adders. Rewind
// deltas are multiplied out at descriptor write time, so the walk itself has no
// multiplier.
// Reset clears tables, counters, offsets, config registers and out_valid; result data is not reset.
// A finished result waits in the output register under out_stall_i while the
// next word is accepted; a second step holds in its emit state until it frees.
`timescale 1ns / 1ps
`default_nettype none

module strided_nd_address_walker #(
  parameter int unsigned MAX_DIMS     = 4,
  parameter int unsigned OFFSET_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [snaw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [snaw_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // input words
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     kind_i,
  input  logic [1:0]                     dim_index_i,
  input  logic [15:0]                    dim_length_i,
  input  logic signed [31:0]             stride_dest_i,
  input  logic signed [31:0]             stride_first_i,
  input  logic signed [31:0]             stride_second_i,
  // result words
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [31:0]                    dst_offset_o,
  output logic [31:0]                    first_offset_o,
  output logic [31:0]                    second_offset_o,
  output logic                           last_o
);
  import snaw_pkg::*;

  // configuration registers; bases only enter the walk on restart
  logic [2:0]  active_dims_q;
  logic [31:0] base_dest_q, base_first_q, base_second_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_dims_q <= '0;
      base_dest_q   <= '0;
      base_first_q  <= '0;
      base_second_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ACTIVE_DIMS: active_dims_q <= cfg_wdata_i[2:0];
        CFG_BASE_DEST:   base_dest_q   <= cfg_wdata_i;
        CFG_BASE_FIRST:  base_first_q  <= cfg_wdata_i;
        CFG_BASE_SECOND: base_second_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  cmd_t    cmd;
  status_t sts;
  logic    out_load, out_free;

  logic [OFFSET_WIDTH-1:0] res_dest, res_first, res_second;
  logic                    res_last;

  snaw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .sts_i      (sts),
    .out_free_i (out_free),
    .in_stall_o (in_stall_o),
    .out_load_o (out_load),
    .cmd_o      (cmd)
  );

  snaw_dpath #(
    .MAX_DIMS     (MAX_DIMS),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .dim_index_i     (dim_index_i),
    .dim_length_i    (dim_length_i),
    .stride_dest_i   (stride_dest_i),
    .stride_first_i  (stride_first_i),
    .stride_second_i (stride_second_i),
    .active_dims_i   (active_dims_q),
    .base_dest_i     (base_dest_q),
    .base_first_i    (base_first_q),
    .base_second_i   (base_second_q),
    .res_dest_o      (res_dest),
    .res_first_o     (res_first),
    .res_second_o    (res_second),
    .res_last_o      (res_last)
  );

  // output register: free when empty or being taken this cycle
  logic        out_valid_q, out_valid_d;
  logic [31:0] dest_q, first_q, second_q;
  logic        last_q;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      dest_q   <= 32'(res_dest);
      first_q  <= 32'(res_first);
      second_q <= 32'(res_second);
      last_q   <= res_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign dst_offset_o    = dest_q;
  assign first_offset_o  = first_q;
  assign second_offset_o = second_q;
  assign last_o          = last_q;

endmodule

`default_nettype wire

### rtl/snaw_ctrl.sv
// Sequencer for the address walker: accepts words, steps the carry walk,
// hands results to the output register. Uses snaw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module snaw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        kind_i,
  input  snaw_pkg::status_t sts_i,
  input  logic              out_free_i,
  output logic              in_stall_o,
  output logic              out_load_o,
  output snaw_pkg::cmd_t    cmd_o
);
  import snaw_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    out_load_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          case (kind_i)
            KIND_DESC:    cmd_o.desc_wr = 1'b1;
            KIND_RESTART: cmd_o.restart = 1'b1;
            KIND_STEP: begin
              cmd_o.start = 1'b1;
              state_d     = sts_i.dims_zero ? ST_EMIT : ST_WALK;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (!sts_i.wrap || sts_i.ptr_zero) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_load_o = out_free_i;
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### rtl/snaw_dpath.sv
// Datapath of the address walker: descriptor tables, rewind deltas, counters,
// running offsets and the captured result. Uses snaw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module snaw_dpath #(
  parameter int unsigned MAX_DIMS     = 4,
  parameter int unsigned OFFSET_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  snaw_pkg::cmd_t           cmd_i,
  output snaw_pkg::status_t        sts_o,
  input  logic [1:0]               dim_index_i,
  input  logic [15:0]              dim_length_i,
  input  logic signed [31:0]       stride_dest_i,
  input  logic signed [31:0]       stride_first_i,
  input  logic signed [31:0]       stride_second_i,
  input  logic [2:0]               active_dims_i,
  input  logic [31:0]              base_dest_i,
  input  logic [31:0]              base_first_i,
  input  logic [31:0]              base_second_i,
  output logic [OFFSET_WIDTH-1:0]  res_dest_o,
  output logic [OFFSET_WIDTH-1:0]  res_first_o,
  output logic [OFFSET_WIDTH-1:0]  res_second_o,
  output logic                     res_last_o
);
  import snaw_pkg::*;

  localparam int unsigned OW     = OFFSET_WIDTH;
  localparam int unsigned DIM_IW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  logic [15:0]        len_q   [MAX_DIMS];
  logic signed [31:0] sd_q    [MAX_DIMS];
  logic signed [31:0] sf_q    [MAX_DIMS];
  logic signed [31:0] ss_q    [MAX_DIMS];
  logic [OW-1:0]      dd_q    [MAX_DIMS];  // (1 - span) * stride, per array
  logic [OW-1:0]      df_q    [MAX_DIMS];
  logic [OW-1:0]      ds_q    [MAX_DIMS];
  logic [15:0]        cnt_q   [MAX_DIMS];

  logic [OW-1:0]     cur_dest_q, cur_first_q, cur_second_q;
  logic [OW-1:0]     res_dest_q, res_first_q, res_second_q;
  logic              last_q;
  logic [DIM_IW-1:0] ptr_q;

  // descriptor decode and rewind delta: (1 - span) * stride
  logic              dim_ok;
  logic [DIM_IW-1:0] dim_idx;
  logic [16:0]       span;
  logic signed [17:0] fac;
  logic signed [49:0] pd_dest, pd_first, pd_second;

  assign dim_ok    = ({30'b0, dim_index_i} < 32'(MAX_DIMS));
  assign dim_idx   = DIM_IW'(dim_index_i);
  assign span      = (dim_length_i == 16'd0) ? 17'h10000 : {1'b0, dim_length_i};
  assign fac       = 18'sd1 - $signed({1'b0, span});
  assign pd_dest   = 50'(fac) * 50'(stride_dest_i);
  assign pd_first  = 50'(fac) * 50'(stride_first_i);
  assign pd_second = 50'(fac) * 50'(stride_second_i);

  // start pointer: innermost active dim, active count saturated at MAX_DIMS
  logic [3:0]        act4;
  logic [DIM_IW-1:0] start_ptr;
  logic              wrap;

  assign act4      = {1'b0, active_dims_i};
  assign start_ptr = (act4 >= 4'(MAX_DIMS)) ? DIM_IW'(MAX_DIMS - 1)
                                            : DIM_IW'(act4 - 4'd1);
  assign wrap      = (cnt_q[ptr_q] == 16'd1);

  assign sts_o.wrap      = wrap;
  assign sts_o.ptr_zero  = (ptr_q == '0);
  assign sts_o.dims_zero = (active_dims_i == 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        len_q[i] <= '0;
        sd_q[i]  <= '0;
        sf_q[i]  <= '0;
        ss_q[i]  <= '0;
        dd_q[i]  <= '0;
        df_q[i]  <= '0;
        ds_q[i]  <= '0;
        cnt_q[i] <= '0;
      end
      cur_dest_q   <= '0;
      cur_first_q  <= '0;
      cur_second_q <= '0;
      ptr_q        <= '0;
      last_q       <= 1'b0;
    end else begin
      if (cmd_i.desc_wr && dim_ok) begin
        len_q[dim_idx] <= dim_length_i;
        sd_q[dim_idx]  <= stride_dest_i;
        sf_q[dim_idx]  <= stride_first_i;
        ss_q[dim_idx]  <= stride_second_i;
        dd_q[dim_idx]  <= OW'(pd_dest);
        df_q[dim_idx]  <= OW'(pd_first);
        ds_q[dim_idx]  <= OW'(pd_second);
      end
      if (cmd_i.restart) begin
        for (int i = 0; i < MAX_DIMS; i++) begin
          cnt_q[i] <= len_q[i];
        end
        cur_dest_q   <= OW'(base_dest_i);
        cur_first_q  <= OW'(base_first_i);
        cur_second_q <= OW'(base_second_i);
      end
      if (cmd_i.start) begin
        ptr_q  <= start_ptr;
        last_q <= sts_o.dims_zero;
      end
      if (cmd_i.walk) begin
        last_q <= wrap;
        ptr_q  <= ptr_q - DIM_IW'(1);
        if (wrap) begin
          cnt_q[ptr_q] <= len_q[ptr_q];
          cur_dest_q   <= cur_dest_q + dd_q[ptr_q];
          cur_first_q  <= cur_first_q + df_q[ptr_q];
          cur_second_q <= cur_second_q + ds_q[ptr_q];
        end else begin
          cnt_q[ptr_q] <= cnt_q[ptr_q] - 16'd1;
          cur_dest_q   <= cur_dest_q + OW'(sd_q[ptr_q]);
          cur_first_q  <= cur_first_q + OW'(sf_q[ptr_q]);
          cur_second_q <= cur_second_q + OW'(ss_q[ptr_q]);
        end
      end
    end
  end

  // result capture: offsets as they stand before the advance
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      res_dest_q   <= cur_dest_q;
      res_first_q  <= cur_first_q;
      res_second_q <= cur_second_q;
    end
  end

  assign res_dest_o   = res_dest_q;
  assign res_first_o  = res_first_q;
  assign res_second_o = res_second_q;
  assign res_last_o   = last_q;

`ifndef SYNTH
  a_restart_loads_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.restart |=> cur_dest_q == OW'($past(base_dest_i)))
    else $error("restart did not load destination base");

  a_walk_decrements: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk && !wrap |=> cnt_q[$past(ptr_q)] == $past(cnt_q[ptr_q]) - 16'd1)
    else $error("non-wrapping advance did not decrement counter");

  a_no_dims_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start && sts_o.dims_zero |=> last_q)
    else $error("step with no active dims not flagged last");
`endif

endmodule

`default_nettype wire
